// ===== src/dwconv_pkg.sv =====
// ----------------------------------------------------------------------------
// dwconv_pkg: shared constants and types
// Sizes, command codes and payload types of the depthwise causal convolution.
// ----------------------------------------------------------------------------
package dwconv_pkg;

	localparam int MAX_CHANNELS = 1024;
	localparam int MAX_TAPS     = 4;
	localparam int HIST_LEN     = MAX_TAPS - 1;

	localparam int CH_W    = 10;
	localparam int VAL_W   = 16;
	localparam int TAP_W   = 4;
	localparam int TAPS_W  = 5;
	localparam int SUM_W   = 36;
	localparam int PROD_W  = 2 * VAL_W;

	localparam int ADDR_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int KW      = $clog2(MAX_TAPS + 1);
	localparam int FILL_W  = $clog2(MAX_TAPS);
	localparam int EPOCH_W = 8;

	localparam logic [TAPS_W-1:0] TAPS_RESET = TAPS_W'(4);

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_PUSH  = 2'd1,
		CMD_START = 2'd2
	} cmd_t;

	typedef logic signed [VAL_W-1:0]  smp_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef smp_t [MAX_TAPS-1:0]      smp_vec_t;
	typedef smp_t [HIST_LEN-1:0]      hist_vec_t;

	// one history memory row per channel; hist[HIST_LEN-1] is the newest
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [FILL_W-1:0]  fill;
		hist_vec_t          hist;
	} hrow_t;

	// operands of one dot product, already masked to the kernel length
	typedef struct packed {
		logic [CH_W-1:0] ch;
		smp_vec_t        win;
		smp_vec_t        wts;
	} dot_req_t;

endpackage

// ===== src/dwconv_dot.sv =====
// ----------------------------------------------------------------------------
// dwconv_dot: multiply lanes and sum register
// One registered product per tap, then an add tree into the output register.
// ----------------------------------------------------------------------------
module dwconv_dot import dwconv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  dot_req_t          req,
	output logic              s2_free,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CH_W-1:0]   out_channel,
	output logic [SUM_W-1:0]  sum
);

	logic                    v_s2;
	logic [CH_W-1:0]         ch_s2;
	prod_t [MAX_TAPS-1:0]    prod_s2;
	logic                    out_valid_q;
	logic [CH_W-1:0]         out_ch_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] acc;
	logic                    out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign s2_free  = !v_s2 || out_free;

	always_comb begin
		acc = '0;
		for (int i = 0; i < MAX_TAPS; i++) begin
			acc = acc + SUM_W'(prod_s2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_free) begin
				v_s2 <= go;
			end
			if (out_free) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && s2_free) begin
			ch_s2 <= req.ch;
			for (int i = 0; i < MAX_TAPS; i++) begin
				prod_s2[i] <= PROD_W'(req.win[i]) * PROD_W'(req.wts[i]);
			end
		end
		if (out_free && v_s2) begin
			out_ch_q <= ch_s2;
			sum_q    <= acc;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_ch_q;
	assign sum         = sum_q;

endmodule

// ===== src/causal_depthwise_conv1d.sv =====
// ----------------------------------------------------------------------------
// causal_depthwise_conv1d: per-channel causal FIR
// History and weights in synchronous memories, read-modify-write per request.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid / in_stall with cmd, channel, tap, value. A request
//   is taken on a rising edge with in_valid high and in_stall low. cmd load
//   writes one weight tap, push appends a sample, start opens a new sequence.
//   Output channel: out_valid / out_stall with out_channel and sum (Q6.30).
//   A push yields a result once its channel holds taps_in_use-1 samples.
//   Config: cfg_wr_en / cfg_wr_data write taps_in_use; write only when idle.
// Pipeline: a taken request passes the memory read registers, the product
//   registers of the multiply lanes and, after the add tree, the output register.
// Throughput: one request per cycle while in_stall stays low. The history
//   memory read-modify-write loop closes through a forwarding register on
//   same-channel back-to-back pushes.
// Reset / clearing: fill counts carry an epoch tag; start bumps the epoch.
//   After reset, and when the epoch wraps (every 256th start), a clearing
//   pass rewrites all MAX_CHANNELS history rows, one per cycle, with
//   in_stall held high. Weights are undefined until loaded.
// Backpressure: while out_stall holds a result, one more result may wait in
//   the product stage and requests that give no result keep flowing.
// ----------------------------------------------------------------------------
module causal_depthwise_conv1d import dwconv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [TAPS_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [CH_W-1:0]   channel,
	input  logic [TAP_W-1:0]  tap,
	input  logic [VAL_W-1:0]  value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CH_W-1:0]   out_channel,
	output logic [SUM_W-1:0]  sum
);

	// storage
	hrow_t    hist_mem [MAX_CHANNELS];
	smp_vec_t wt_mem   [MAX_CHANNELS];

	// control state
	logic [TAPS_W-1:0]  taps_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               clear_q;
	logic [ADDR_W-1:0]  ptr_q;
	logic               v_s1;

	// stage 1 payload
	logic [1:0]        cmd_s1;
	logic [CH_W-1:0]   ch_s1;
	logic [TAP_W-1:0]  tap_s1;
	smp_t              val_s1;
	hrow_t             hrd_s1;
	smp_vec_t          wrd_s1;
	logic              fwdh_s1;
	logic              fwdw_s1;
	hrow_t             fwdhrow_s1;
	smp_vec_t          fwdwrow_s1;

	// stage 1 logic
	logic [KW-1:0]     k;
	logic              accept;
	logic              ch_ok;
	logic              is_push;
	logic              is_load;
	logic              is_start;
	logic              emit;
	logic              s1_go;
	logic              s2_free;
	logic              wrap_blk;
	logic              hwe_item;
	logic              wwe_item;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] addr_s1;
	hrow_t             hrow;
	smp_vec_t          wrow;
	logic [FILL_W-1:0] fill_eff;
	hrow_t             hrow_new;
	smp_vec_t          wrow_new;
	logic              hwe;
	logic [ADDR_W-1:0] hw_addr;
	hrow_t             hw_data;
	dot_req_t          req;

	// effective kernel length, saturated into 1..MAX_TAPS
	always_comb begin
		if (taps_q == '0) begin
			k = KW'(1);
		end else if (32'(taps_q) > MAX_TAPS) begin
			k = KW'(MAX_TAPS);
		end else begin
			k = KW'(taps_q);
		end
	end

	assign rd_addr = ADDR_W'(channel);
	assign addr_s1 = ADDR_W'(ch_s1);

	// forwarded rows cover a write to the same channel on the accept edge
	assign hrow = fwdh_s1 ? fwdhrow_s1 : hrd_s1;
	assign wrow = fwdw_s1 ? fwdwrow_s1 : wrd_s1;

	// stale epoch tag means the channel is empty in this sequence
	assign fill_eff = (hrow.epoch == epoch_q) ? hrow.fill : '0;

	assign ch_ok    = 32'(ch_s1) < MAX_CHANNELS;
	assign is_push  = v_s1 && (cmd_s1 == CMD_PUSH) && ch_ok;
	assign is_load  = v_s1 && (cmd_s1 == CMD_LOAD) && ch_ok && (32'(tap_s1) < 32'(k));
	assign is_start = v_s1 && (cmd_s1 == CMD_START);
	assign emit     = is_push && (32'(fill_eff) >= 32'(k) - 1);

	assign s1_go    = v_s1 && (!emit || s2_free);
	assign wrap_blk = is_start && (epoch_q == '1);
	assign in_stall = (v_s1 && !s1_go) || clear_q || wrap_blk;
	assign accept   = in_valid && !in_stall;

	assign hwe_item = s1_go && is_push;
	assign wwe_item = s1_go && is_load;

	// history shift, fill update
	always_comb begin
		hrow_new       = hrow;
		hrow_new.epoch = epoch_q;
		for (int i = 0; i < HIST_LEN - 1; i++) begin
			hrow_new.hist[i] = hrow.hist[i+1];
		end
		hrow_new.hist[HIST_LEN-1] = val_s1;
		if (32'(fill_eff) < HIST_LEN) begin
			hrow_new.fill = fill_eff + FILL_W'(1);
		end else begin
			hrow_new.fill = fill_eff;
		end
	end

	// weight lane replace
	always_comb begin
		wrow_new = wrow;
		for (int i = 0; i < MAX_TAPS; i++) begin
			if (32'(tap_s1) == i) begin
				wrow_new[i] = val_s1;
			end
		end
	end

	// window: newest k-1 history samples oldest first, then the new sample
	always_comb begin
		req.ch  = ch_s1;
		req.win = '0;
		req.wts = '0;
		for (int i = 0; i < MAX_TAPS; i++) begin
			if (i < 32'(k)) begin
				req.wts[i] = wrow[i];
			end
			if (i == 32'(k) - 1) begin
				req.win[i] = val_s1;
			end else if (i < 32'(k) - 1) begin
				for (int j = 0; j < HIST_LEN; j++) begin
					if (j == i + MAX_TAPS - 32'(k)) begin
						req.win[i] = hrow.hist[j];
					end
				end
			end
		end
	end

	// history write port: clearing pass or pipeline write-back
	assign hwe     = clear_q || hwe_item;
	assign hw_addr = clear_q ? ptr_q : addr_s1;
	assign hw_data = clear_q ? hrow_t'('0) : hrow_new;

	always_ff @(posedge clk) begin
		if (hwe) begin
			hist_mem[hw_addr] <= hw_data;
		end
		if (wwe_item) begin
			wt_mem[addr_s1] <= wrow_new;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hrd_s1 <= hist_mem[rd_addr];
			wrd_s1 <= wt_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q  <= TAPS_RESET;
			epoch_q <= '0;
			clear_q <= 1'b1;
			ptr_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				taps_q <= cfg_wr_data;
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (clear_q) begin
				ptr_q <= ptr_q + ADDR_W'(1);
				if (ptr_q == ADDR_W'(MAX_CHANNELS - 1)) begin
					clear_q <= 1'b0;
				end
			end
			if (s1_go && is_start) begin
				if (wrap_blk) begin
					// epoch wraps: sweep the history rows once more
					epoch_q <= '0;
					clear_q <= 1'b1;
					ptr_q   <= '0;
				end else begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd;
			ch_s1      <= channel;
			tap_s1     <= tap;
			val_s1     <= value;
			fwdh_s1    <= hwe_item && (addr_s1 == rd_addr);
			fwdw_s1    <= wwe_item && (addr_s1 == rd_addr);
			fwdhrow_s1 <= hrow_new;
			fwdwrow_s1 <= wrow_new;
		end
	end

	dwconv_dot u_dot (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (s1_go && emit),
		.req         (req),
		.s2_free     (s2_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_channel (out_channel),
		.sum         (sum)
	);

	// stage 1 is empty while the clearing pass owns the history port
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clear_q |-> !v_s1)
		else $error("request in stage 1 during clearing pass");

	// a clearing pass always starts from epoch zero
	a_clear_epoch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(clear_q) |-> (epoch_q == '0))
		else $error("clearing pass started with nonzero epoch");

	// a forwarding hit needs a history write-back on the accept edge
	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (!fwdh_s1 || $past(hwe_item)))
		else $error("history forward without a write-back");

endmodule
